// ----- rtl/core/sdq_pkg.sv -----
// Package: shared types and constants of the spot dedup queue.
package sdq_pkg;
   localparam int CallWidth = 48;
   localparam logic [15:0] WINDOW_RESET = 16'd300;
   localparam logic [6:0] THRESHOLD_RESET = 7'd40;
   localparam logic [6:0] MAX_OUT = 7'd64;

   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_TAKE = 2'd1,
      CMD_DROP = 2'd2,
      CMD_RSVD = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_QUEUED     = 4'd0,
      ST_SUPPRESSED = 4'd1,
      ST_REPLACED   = 4'd2,
      ST_KEPT       = 4'd3,
      ST_INVALID    = 4'd4,
      ST_FULL       = 4'd5,
      ST_TAKEN      = 4'd6,
      ST_NONE       = 4'd7,
      ST_DROPPED    = 4'd8
   } status_type;

   localparam logic [0:0] REG_WINDOW = 1'b0;
   localparam logic [0:0] REG_THRESH = 1'b1;

   // Clear every byte after the first zero byte of the callsign.
   function automatic logic [95:0] norm_call(input logic [95:0] c);
      logic [95:0] r;
      logic ended;
      r = c;
      ended = 1'b0;
      for (int i = 0; i < 12; i++) begin
         if (ended) r[95-8*i -: 8] = 8'd0;
         else if (c[95-8*i -: 8] == 8'd0) ended = 1'b1;
      end
      return r;
   endfunction
endpackage

// ----- rtl/core/spot_dedup_queue.sv -----
// Top level: spot dedup queue and recent-sent table, both in registered-read memories.
// Each item is handled one at a time. An enqueue scans the recent table one slot a
// cycle and then the queued entries one a cycle. A take, for each entry, waits until
// the previous result is taken, then reads the queue head and scans the recent table
// until a matching or empty slot is found, else the whole table, to pick a slot.
// After reset a clearing pass empties every slot of the recent table; no item is
// accepted meanwhile, but configuration writes are.
module spot_dedup_queue #(
   parameter int QUEUE_DEPTH  = 256,
   parameter int RECENT_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [47:0] req_call_high,
   input  logic [47:0] req_call_low,
   input  logic [31:0] req_frequency,
   input  logic signed [7:0] req_snr,
   input  logic [31:0] req_flow_start,
   input  logic [31:0] req_now,
   input  logic [6:0]  req_take_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [8:0]  rsp_pending,
   output logic        rsp_flush_due,
   output logic [47:0] rsp_out_call_high,
   output logic [47:0] rsp_out_call_low,
   output logic [31:0] rsp_out_frequency,
   output logic signed [7:0] rsp_out_snr,
   output logic [31:0] rsp_out_start,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sdq_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int RAW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] QFULL = CW'(QUEUE_DEPTH);
   localparam logic [RAW-1:0] RLAST = RAW'(RECENT_DEPTH - 1);
   localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_RSCAN  = 11'b00000000100,
      S_QSCAN  = 11'b00000001000,
      S_TREAD  = 11'b00000010000,
      S_TSCAN  = 11'b00000100000,
      S_TWRITE = 11'b00001000000,
      S_OUT    = 11'b00010000000,
      S_REPL   = 11'b00100000000,
      S_APPEND = 11'b01000000000,
      S_DROP   = 11'b10000000000
   } state_type;

   // memories
   logic [95:0]  qcall_mem [QUEUE_DEPTH];
   logic [71:0]  qdata_mem [QUEUE_DEPTH];   // freq, snr, start
   logic [127:0] rec_mem   [RECENT_DEPTH];  // call, time

   state_type state_ff, state_in;
   logic [15:0] window_ff;
   logic [6:0]  thresh_ff;
   logic [QAW-1:0] head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [95:0] call_ff, call_in;
   logic [31:0] freq_ff, freq_in, start_ff, start_in, now_ff, now_in;
   logic [7:0]  snr_ff, snr_in;
   logic [RAW-1:0] ridx_ff, ridx_in;
   logic [CW-1:0]  qidx_ff, qidx_in;
   logic        rd_live_ff, rd_live_in;   // a read was issued last cycle
   logic [6:0]  left_ff, left_in;
   logic [RAW-1:0] slot_ff, slot_in;
   logic [31:0] oldest_ff, oldest_in;
   logic        found_ff, found_in;
   logic [QAW-1:0] hit_ff, hit_in;

   logic [127:0] rec_rd_ff;
   logic [95:0]  qcall_rd_ff;
   logic [71:0]  qdata_rd_ff;

   logic         rec_re, rec_we, q_re, qc_we, qd_we;
   logic [RAW-1:0] rec_ra, rec_wa;
   logic [127:0] rec_wd;
   logic [QAW-1:0] q_ra, q_wa;
   logic [95:0]  qc_wd;
   logic [71:0]  qd_wd;

   logic        rv_ff, rv_in;
   logic [3:0]  rs_ff, rs_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic [95:0] rc_ff, rc_in;
   logic [71:0] rd_ff, rd_in;
   logic        rl_ff, rl_in;

   logic csr_wr;
   logic [95:0] ncall;
   logic [6:0]  take_n;
   logic [QAW-1:0] tail;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_THRESH) ? {25'd0, thresh_ff} : {16'd0, window_ff};
   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign ncall = norm_call({req_call_high, req_call_low});

   always_comb begin
      logic [6:0] n;
      n = req_take_count;
      if ({{(CW > 7 ? CW-7 : 0){1'b0}}, n} > count_ff) n = 7'(count_ff);
      if (n > thresh_ff) n = thresh_ff;
      if (n > MAX_OUT) n = MAX_OUT;
      take_n = n;
   end

   function automatic logic [QAW-1:0] qwrap(input logic [QAW-1:0] h, input logic [CW-1:0] k);
      logic [CW:0] s;
      s = {{(CW+1-QAW){1'b0}}, h} + {1'b0, k};
      if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
      return QAW'(s);
   endfunction

   assign tail = qwrap(head_ff, count_ff);

   always_comb begin
      logic [95:0] rcall;
      logic [31:0] rtime;
      logic [32:0] age;
      logic        rmatch;
      state_in = state_ff;
      head_in = head_ff; count_in = count_ff;
      call_in = call_ff; freq_in = freq_ff; start_in = start_ff; now_in = now_ff;
      snr_in = snr_ff; ridx_in = ridx_ff; qidx_in = qidx_ff; rd_live_in = 1'b0;
      left_in = left_ff; slot_in = slot_ff; oldest_in = oldest_ff;
      found_in = found_ff; hit_in = hit_ff;
      rec_re = 1'b0; rec_ra = ridx_ff; rec_we = 1'b0; rec_wa = ridx_ff; rec_wd = '0;
      q_re = 1'b0; q_ra = head_ff; qc_we = 1'b0; qd_we = 1'b0; q_wa = tail;
      qc_wd = call_ff; qd_wd = {freq_ff, snr_ff, start_ff};
      rv_in = rv_ff && rsp_stall; rs_in = rs_ff; rp_in = rp_ff; rc_in = rc_ff;
      rd_in = rd_ff; rl_in = rl_ff;
      rcall = rec_rd_ff[127:32];
      rtime = rec_rd_ff[31:0];
      // age in full range: a stamp in the future gives a negative age
      age = {1'b0, now_ff} - {1'b0, rtime};
      rmatch = (rcall == call_ff);

      unique case (state_ff)
         S_CLEAR: begin
            rec_we = 1'b1; rec_wa = ridx_ff;
            ridx_in = ridx_ff + 1'b1;
            if (ridx_ff == RLAST) begin
               ridx_in = '0; state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               call_in = ncall; freq_in = req_frequency; snr_in = req_snr;
               start_in = req_flow_start; now_in = req_now;
               ridx_in = '0; qidx_in = '0; found_in = 1'b0;
               rs_in = ST_NONE; rc_in = '0; rd_in = '0; rl_in = 1'b1; rp_in = count_ff;
               unique case (cmd_type'(req_cmd))
                  CMD_ENQ: begin
                     if (ncall[95:88] == 8'd0 || req_frequency == 32'd0) begin
                        rs_in = ST_INVALID; rv_in = 1'b1;
                     end else begin
                        rec_re = 1'b1; rec_ra = '0; rd_live_in = 1'b1;
                        state_in = S_RSCAN;
                     end
                  end
                  CMD_TAKE: begin
                     if (take_n == 7'd0) rv_in = 1'b1;
                     else begin
                        left_in = take_n; state_in = S_TREAD;
                     end
                  end
                  CMD_DROP: begin
                     if (count_ff != '0) state_in = S_DROP;
                     else rv_in = 1'b1;
                  end
                  default: rv_in = 1'b1;
               endcase
            end
         end
         S_RSCAN: begin
            if (rmatch && $signed(age) < $signed({17'd0, window_ff})) begin
               rs_in = ST_SUPPRESSED; rv_in = 1'b1; state_in = S_IDLE;
            end else if (ridx_ff == RLAST) begin
               if (count_ff != '0) begin
                  q_re = 1'b1; q_ra = head_ff; rd_live_in = 1'b1;
               end
               state_in = S_QSCAN;
            end else begin
               rec_re = 1'b1; rec_ra = ridx_ff + 1'b1; ridx_in = ridx_ff + 1'b1;
               rd_live_in = 1'b1;
            end
         end
         S_QSCAN: begin
            if (!rd_live_ff) begin
               if (count_ff >= QFULL) begin
                  rs_in = ST_FULL; rv_in = 1'b1; state_in = S_IDLE;
               end else state_in = S_APPEND;
            end else if (qcall_rd_ff == call_ff) begin
               hit_in = qwrap(head_ff, qidx_ff);
               if ($signed(snr_ff) > $signed(qdata_rd_ff[39:32])) state_in = S_REPL;
               else begin
                  rs_in = ST_KEPT; rv_in = 1'b1; state_in = S_IDLE;
               end
            end else begin
               qidx_in = qidx_ff + 1'b1;
               if (qidx_ff + 1'b1 < count_ff) begin
                  q_re = 1'b1; q_ra = qwrap(head_ff, qidx_ff + 1'b1); rd_live_in = 1'b1;
               end
            end
         end
         S_REPL: begin
            qd_we = 1'b1; q_wa = hit_ff;
            rs_in = ST_REPLACED; rv_in = 1'b1; state_in = S_IDLE;
         end
         S_APPEND: begin
            qc_we = 1'b1; qd_we = 1'b1; q_wa = tail;
            count_in = count_ff + 1'b1;
            rs_in = ST_QUEUED; rp_in = count_ff + 1'b1; rv_in = 1'b1; state_in = S_IDLE;
         end
         S_DROP: begin
            head_in = (head_ff == QLAST) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            rs_in = ST_DROPPED; rp_in = count_ff - 1'b1; rv_in = 1'b1; state_in = S_IDLE;
         end
         S_TREAD: begin
            if (!rv_ff) begin
               q_re = 1'b1; q_ra = head_ff;
               rec_re = 1'b1; rec_ra = '0; rd_live_in = 1'b1;
               ridx_in = '0; found_in = 1'b0; slot_in = '0;
               state_in = S_TSCAN;
            end
         end
         S_TSCAN: begin
            // first-cycle data: capture head entry
            if (ridx_ff == '0) begin
               call_in = qcall_rd_ff; rd_in = qdata_rd_ff; oldest_in = rtime;
            end
            if (!found_ff) begin
               if (((ridx_ff == '0) ? (rcall == qcall_rd_ff) : rmatch) ||
                   rcall[95:88] == 8'd0) begin
                  found_in = 1'b1; slot_in = ridx_ff;
               end else if (ridx_ff != '0 && rtime < oldest_ff) begin
                  oldest_in = rtime; slot_in = ridx_ff;
               end
            end
            if (ridx_ff == RLAST || found_in) state_in = S_TWRITE;
            else begin
               rec_re = 1'b1; rec_ra = ridx_ff + 1'b1; ridx_in = ridx_ff + 1'b1;
            end
         end
         S_TWRITE: begin
            rec_we = 1'b1; rec_wa = slot_ff; rec_wd = {call_ff, now_ff};
            head_in = (head_ff == QLAST) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            left_in = left_ff - 1'b1;
            rs_in = ST_TAKEN; rp_in = count_ff - 1'b1; rc_in = call_ff; rd_in = rd_ff;
            rl_in = (left_ff == 7'd1); rv_in = 1'b1;
            state_in = (left_ff == 7'd1) ? S_IDLE : S_TREAD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rec_we) rec_mem[rec_wa] <= rec_wd;
      if (rec_re) rec_rd_ff <= rec_mem[rec_ra];
      if (qc_we) qcall_mem[q_wa] <= qc_wd;
      if (qd_we) qdata_mem[q_wa] <= qd_wd;
      if (q_re) begin
         qcall_rd_ff <= qcall_mem[q_ra];
         qdata_rd_ff <= qdata_mem[q_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         window_ff <= WINDOW_RESET; thresh_ff <= THRESHOLD_RESET;
         head_ff <= '0; count_ff <= '0; ridx_ff <= '0; qidx_ff <= '0;
         rd_live_ff <= 1'b0; rv_ff <= 1'b0; found_ff <= 1'b0; left_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; count_ff <= count_in; ridx_ff <= ridx_in;
         qidx_ff <= qidx_in; rd_live_ff <= rd_live_in; rv_ff <= rv_in;
         found_ff <= found_in; left_ff <= left_in;
         if (csr_wr && csr_paddr[1:0] == 2'b00 && csr_paddr[2] == REG_WINDOW)
            window_ff <= csr_pwdata[15:0];
         if (csr_wr && csr_paddr[1:0] == 2'b00 && csr_paddr[2] == REG_THRESH)
            thresh_ff <= csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      call_ff <= call_in; freq_ff <= freq_in; start_ff <= start_in; now_ff <= now_in;
      snr_ff <= snr_in; slot_ff <= slot_in; oldest_ff <= oldest_in; hit_ff <= hit_in;
      rs_ff <= rs_in; rp_ff <= rp_in; rc_ff <= rc_in; rd_ff <= rd_in; rl_ff <= rl_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_pending = 9'(rp_ff);
   assign rsp_flush_due = (rsp_pending >= {2'b00, thresh_ff});
   assign rsp_out_call_high = rc_ff[95:48];
   assign rsp_out_call_low = rc_ff[47:0];
   assign rsp_out_frequency = rd_ff[71:40];
   assign rsp_out_snr = rd_ff[39:32];
   assign rsp_out_start = rd_ff[31:0];
   assign rsp_last = rl_ff;

   a_count: assert property (@(posedge clock) disable iff (reset) count_ff <= QFULL)
      else $error("queue count overflow");
   a_nostall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall) else $error("accept during clear");
   a_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TWRITE) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("take did not remove entry");
endmodule

// ----- bench/sdq_checker.sv -----
// Checker: predicts the spot dedup queue's results and compares them with the block's output.
module sdq_checker
   import sdq_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 256,
   parameter int RECENT_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [47:0] req_call_high,
   input  logic [47:0] req_call_low,
   input  logic [31:0] req_frequency,
   input  logic signed [7:0] req_snr,
   input  logic [31:0] req_flow_start,
   input  logic [31:0] req_now,
   input  logic [6:0]  req_take_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [8:0]  rsp_pending,
   input  logic        rsp_flush_due,
   input  logic [47:0] rsp_out_call_high,
   input  logic [47:0] rsp_out_call_low,
   input  logic [31:0] rsp_out_frequency,
   input  logic signed [7:0] rsp_out_snr,
   input  logic [31:0] rsp_out_start,
   input  logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fails,
   output int          outstanding
);
   typedef struct packed {
      logic [3:0]  status;
      logic [8:0]  pending;
      logic        flush_due;
      logic [47:0] call_high;
      logic [47:0] call_low;
      logic [31:0] frequency;
      logic [7:0]  snr;
      logic [31:0] start;
      logic        last;
   } spot_result;

   spot_result due_results[$];

   logic [47:0] queued_high [QUEUE_DEPTH];
   logic [47:0] queued_low  [QUEUE_DEPTH];
   logic [31:0] queued_freq [QUEUE_DEPTH];
   logic [7:0]  queued_snr  [QUEUE_DEPTH];
   logic [31:0] queued_start[QUEUE_DEPTH];
   int          head_idx;
   int          pending_cnt;
   logic [47:0] sent_high[RECENT_DEPTH];
   logic [47:0] sent_low [RECENT_DEPTH];
   logic [31:0] sent_time[RECENT_DEPTH];
   logic [15:0] window;
   logic [6:0]  threshold;
   int          errs;

   assign fails = errs;

   function automatic spot_result blank_result(input status_type st);
      spot_result r;
      r = '0;
      r.status = st;
      r.pending = 9'(pending_cnt);
      r.flush_due = (pending_cnt >= threshold);
      r.last = 1'b1;
      return r;
   endfunction

   // Zero everything past the terminating null of the callsign.
   function automatic logic [95:0] trim_call(input logic [95:0] raw);
      logic [95:0] r;
      logic seen_null;
      r = '0;
      seen_null = 1'b0;
      for (int b = 11; b >= 0; b--) begin
         if (!seen_null && raw[8*b +: 8] == 8'd0) seen_null = 1'b1;
         if (!seen_null) r[8*b +: 8] = raw[8*b +: 8];
      end
      return r;
   endfunction

   task automatic stamp_sent(input logic [47:0] hi, input logic [47:0] lo,
                             input logic [31:0] stamp);
      int slot;
      logic [31:0] oldest;
      slot = 0;
      oldest = sent_time[0];
      for (int i = 0; i < RECENT_DEPTH; i++) begin
         if ((sent_high[i] == hi && sent_low[i] == lo) || sent_high[i][47:40] == 8'd0) begin
            slot = i;
            break;
         end
         if (sent_time[i] < oldest) begin
            oldest = sent_time[i];
            slot = i;
         end
      end
      sent_high[slot] = hi;
      sent_low[slot] = lo;
      sent_time[slot] = stamp;
   endtask

   task automatic enqueue_spot();
      logic [95:0] call;
      status_type st;
      int idx;
      logic done;
      call = trim_call({req_call_high, req_call_low});
      done = 1'b0;
      st = ST_QUEUED;
      if (call[95:88] == 8'd0 || req_frequency == 32'd0) begin
         st = ST_INVALID;
         done = 1'b1;
      end
      for (int i = 0; i < RECENT_DEPTH && !done; i++)
         if (sent_high[i] == call[95:48] && sent_low[i] == call[47:0] &&
             longint'(req_now) - longint'(sent_time[i]) < longint'(window)) begin
            st = ST_SUPPRESSED;
            done = 1'b1;
         end
      for (int k = 0; k < pending_cnt && !done; k++) begin
         idx = (head_idx + k) % QUEUE_DEPTH;
         if (queued_high[idx] == call[95:48] && queued_low[idx] == call[47:0]) begin
            done = 1'b1;
            st = ST_KEPT;
            if (req_snr > $signed(queued_snr[idx])) begin
               st = ST_REPLACED;
               queued_freq[idx] = req_frequency;
               queued_snr[idx] = req_snr;
               queued_start[idx] = req_flow_start;
            end
         end
      end
      if (!done && pending_cnt >= QUEUE_DEPTH) begin
         st = ST_FULL;
         done = 1'b1;
      end
      if (!done) begin
         idx = (head_idx + pending_cnt) % QUEUE_DEPTH;
         queued_high[idx] = call[95:48];
         queued_low[idx] = call[47:0];
         queued_freq[idx] = req_frequency;
         queued_snr[idx] = req_snr;
         queued_start[idx] = req_flow_start;
         pending_cnt++;
      end
      due_results.push_back(blank_result(st));
   endtask

   task automatic take_batch();
      int n;
      int h;
      spot_result r;
      n = req_take_count;
      if (n > pending_cnt) n = pending_cnt;
      if (n > threshold) n = threshold;
      if (n > MAX_OUT) n = MAX_OUT;
      if (n == 0) due_results.push_back(blank_result(ST_NONE));
      for (int k = 0; k < n; k++) begin
         h = head_idx;
         stamp_sent(queued_high[h], queued_low[h], req_now);
         head_idx = (h + 1) % QUEUE_DEPTH;
         pending_cnt--;
         r = blank_result(ST_TAKEN);
         r.call_high = queued_high[h];
         r.call_low = queued_low[h];
         r.frequency = queued_freq[h];
         r.snr = queued_snr[h];
         r.start = queued_start[h];
         r.last = (k == n - 1);
         due_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      spot_result want, got;
      if (reset) begin
         for (int i = 0; i < RECENT_DEPTH; i++) begin
            sent_high[i] = '0;
            sent_low[i] = '0;
            sent_time[i] = '0;
         end
         head_idx = 0;
         pending_cnt = 0;
         window = WINDOW_RESET;
         threshold = THRESHOLD_RESET;
         errs = 0;
         due_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_WINDOW) window = csr_pwdata[15:0];
            else threshold = csr_pwdata[6:0];
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_pending, rsp_flush_due, rsp_out_call_high,
                   rsp_out_call_low, rsp_out_frequency, rsp_out_snr, rsp_out_start,
                   rsp_last};
            if (due_results.size() == 0) begin
               if (errs < 10) $display("unexpected result: %p", got);
               errs++;
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  if (errs < 10) begin
                     $display("mismatch: expected %p", want);
                     $display("          actual   %p", got);
                  end
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_ENQ:  enqueue_spot();
               CMD_TAKE: take_batch();
               CMD_DROP: begin
                  if (pending_cnt > 0) begin
                     head_idx = (head_idx + 1) % QUEUE_DEPTH;
                     pending_cnt--;
                     due_results.push_back(blank_result(ST_DROPPED));
                  end else begin
                     due_results.push_back(blank_result(ST_NONE));
                  end
               end
               default:  due_results.push_back(blank_result(ST_NONE));
            endcase
         end
      end
      outstanding <= due_results.size();
   end
endmodule

// ----- bench/tb.sv -----
// Testbench top: drives spot items and register writes into the dedup queue and gives the verdict.
module tb;
   import sdq_pkg::*;

   localparam int RECENT_DEPTH = 256;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [47:0] req_call_high = '0;
   logic [47:0] req_call_low = '0;
   logic [31:0] req_frequency = '0;
   logic signed [7:0] req_snr = '0;
   logic [31:0] req_flow_start = '0;
   logic [31:0] req_now = '0;
   logic [6:0]  req_take_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [8:0]  rsp_pending;
   logic        rsp_flush_due;
   logic [47:0] rsp_out_call_high;
   logic [47:0] rsp_out_call_low;
   logic [31:0] rsp_out_frequency;
   logic signed [7:0] rsp_out_snr;
   logic [31:0] rsp_out_start;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fails;
   int          outstanding;

   int          idle_pct = 0;
   int          stall_pct = 0;
   logic [31:0] cur_now = 32'd5000;
   logic [95:0] call_pool[16];

   spot_dedup_queue dut (.*);
   sdq_checker chk (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

   initial begin
      #60000000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_item(input logic [1:0] cmd, input logic [95:0] call,
                            input logic [31:0] freq, input logic [7:0] snr,
                            input logic [31:0] now, input logic [6:0] take);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_cmd <= cmd;
      {req_call_high, req_call_low} <= call;
      req_frequency <= freq;
      req_snr <= snr;
      req_flow_start <= $urandom;
      req_now <= now;
      req_take_count <= take;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic enq(input logic [95:0] call, input logic [31:0] freq,
                      input logic [7:0] snr, input logic [31:0] now);
      send_item(CMD_ENQ, call, freq, snr, now, 7'($urandom_range(64)));
   endtask

   task automatic ctl(input cmd_type cmd, input logic [6:0] take, input logic [31:0] now);
      send_item(cmd, {$urandom, $urandom, $urandom}, $urandom, 8'($urandom), now, take);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold off until every result is back and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (RECENT_DEPTH + 20) @(posedge clock);
   endtask

   // Fill the bytes after the terminating null with rubbish.
   function automatic logic [95:0] add_junk(input logic [95:0] c);
      logic [95:0] r;
      logic ended;
      r = c;
      ended = 1'b0;
      for (int b = 11; b >= 0; b--) begin
         if (ended) r[8*b +: 8] = 8'($urandom);
         else if (c[8*b +: 8] == 8'd0) ended = 1'b1;
      end
      return r;
   endfunction

   task automatic random_item();
      int pick;
      logic [95:0] call;
      pick = $urandom_range(99);
      cur_now = cur_now + $urandom_range(150);
      if (pick < 55) begin
         call = call_pool[$urandom_range(15)];
         if ($urandom_range(1)) call = add_junk(call);
         enq(call, ($urandom_range(15) == 0) ? 32'd0 : $urandom, 8'($urandom), cur_now);
      end else if (pick < 60) begin
         if ($urandom_range(1)) call = {8'h00, $urandom, $urandom, 24'($urandom)};
         else call = {$urandom, $urandom, $urandom};
         enq(call, $urandom, 8'($urandom), cur_now);
      end else if (pick < 78) begin
         ctl(CMD_TAKE, ($urandom_range(3) == 0) ? 7'($urandom_range(64))
                                                : 7'($urandom_range(4)), cur_now);
      end else if (pick < 90) begin
         ctl(CMD_DROP, 7'($urandom_range(64)), cur_now);
      end else if (pick < 94) begin
         ctl(CMD_RSVD, 7'($urandom_range(64)), cur_now);
      end else begin
         send_item(2'($urandom_range(3)), {$urandom, $urandom, $urandom}, $urandom,
                   8'($urandom), $urandom, 7'($urandom_range(64)));
      end
   endtask

   initial begin
      int len;
      logic [9:0] n;
      for (int p = 0; p < 16; p++) begin
         len = $urandom_range(1, 12);
         call_pool[p] = '0;
         for (int b = 0; b < len; b++) call_pool[p][95-8*b -: 8] = 8'($urandom_range(1, 255));
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_WINDOW, 32'd300);
      write_reg(REG_THRESH, 32'd40);
      ctl(CMD_TAKE, 7'd64, 32'd100);
      ctl(CMD_DROP, 7'd0, 32'd100);
      ctl(CMD_RSVD, 7'd5, 32'd100);
      enq({8'h00, $urandom, $urandom, 24'($urandom)}, 32'd7000000, 8'd10, 32'd100);
      enq({"K1ABC", 56'd0}, 32'd0, 8'd5, 32'd100);
      enq({"K1ABC", 56'd0}, 32'hFFFF_FFFF, 8'h80, 32'd100);
      enq({"K1ABC", 8'h00, 48'hA5C3_5A3C_FF01}, 32'd14074000, 8'h80, 32'd100);
      enq({"K1ABC", 56'd0}, 32'd14074000, 8'h7F, 32'd100);
      enq({12{8'hFF}}, 32'd1, 8'd0, 32'd100);
      enq({"G4XYZ/P", 40'd0}, 32'd10136000, 8'hF0, 32'd100);
      ctl(CMD_TAKE, 7'd0, 32'd1000);
      ctl(CMD_TAKE, 7'd2, 32'd1000);
      // one second short of the window, then exactly on it
      enq({"K1ABC", 56'd0}, 32'd7074000, 8'd1, 32'd1299);
      enq({"K1ABC", 56'd0}, 32'd7074000, 8'd1, 32'd1300);
      // stamp lies in the future
      enq({12{8'hFF}}, 32'd7074000, 8'd1, 32'd10);
      ctl(CMD_DROP, 7'd0, 32'd1300);
      settle();
      write_reg(REG_WINDOW, 32'd0);
      write_reg(REG_THRESH, 32'd1);
      enq({"DL1AAA", 48'd0}, 32'd7074000, 8'd3, 32'd1300);
      enq({12{8'hFF}}, 32'd7074000, 8'd3, 32'd999);
      ctl(CMD_TAKE, 7'd64, 32'd2000);
      settle();

      // fill the queue to the brim, then drain it through the recent table
      write_reg(REG_WINDOW, 32'd65535);
      write_reg(REG_THRESH, 32'd64);
      for (int i = 0; i < 258; i++) begin
         n = 10'(i);
         enq({24'h464C4C, 1'b1, n[6:0], 5'b10000, n[9:7], 8'h5A, 48'd0},
             $urandom | 32'd1, 8'($urandom), cur_now);
      end
      enq({24'h464C4C, 8'h80, 8'h80, 8'h5A, 48'd0}, 32'd50313000, 8'($urandom), cur_now);
      for (int i = 0; i < 5; i++) ctl(CMD_TAKE, 7'd64, cur_now + i);
      settle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
               write_reg(REG_WINDOW, 32'd300);
               write_reg(REG_THRESH, 32'd40);
            end
            1: begin
               idle_pct = 68;
               stall_pct = 0;
               write_reg(REG_WINDOW, 32'd0);
               write_reg(REG_THRESH, 32'd1);
            end
            2: begin
               idle_pct = 0;
               stall_pct = 68;
               write_reg(REG_WINDOW, $urandom_range(65535));
               write_reg(REG_THRESH, $urandom_range(1, 64));
            end
            default: begin
               idle_pct = 27;
               stall_pct = 27;
               write_reg(REG_WINDOW, 32'd65535);
               write_reg(REG_THRESH, 32'd64);
            end
         endcase
         repeat (55) random_item();
         settle();
      end

      if (fails == 0 && outstanding == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/core/sdq_pkg.sv
rtl/core/spot_dedup_queue.sv
bench/sdq_checker.sv
bench/tb.sv
